@@ rtl/qje_pkg.sv @@
// Shared types and constants for the quaternion Julia escape-time block.
// Used by qje_ctrl, qje_datapath, quaternion_julia_escape and the testbench; depends on nothing.
package qje_pkg;

  localparam int IN_W    = 16;  // point coordinates and Julia constant, signed
  localparam int NORM_W  = 20;  // saturated squared norm, unsigned
  localparam int STEPS_W = 5;   // reported step count
  localparam int LIMIT_W = 5;   // iteration limit register
  localparam int SEL_W   = 3;   // product selector

  localparam logic [NORM_W-1:0] NORM_MAX = '1;

  // Configuration register indexes.
  localparam logic [2:0] REG_CONST_REAL = 3'd0;
  localparam logic [2:0] REG_CONST_I    = 3'd1;
  localparam logic [2:0] REG_CONST_J    = 3'd2;
  localparam logic [2:0] REG_CONST_K    = 3'd3;
  localparam logic [2:0] REG_SLICE_W    = 3'd4;
  localparam logic [2:0] REG_ITER_LIMIT = 3'd5;

  // Product selectors: the four squares, then r times each imaginary part.
  localparam logic [SEL_W-1:0] SEL_RR = 3'd0;
  localparam logic [SEL_W-1:0] SEL_II = 3'd1;
  localparam logic [SEL_W-1:0] SEL_JJ = 3'd2;
  localparam logic [SEL_W-1:0] SEL_KK = 3'd3;
  localparam logic [SEL_W-1:0] SEL_RI = 3'd4;
  localparam logic [SEL_W-1:0] SEL_RJ = 3'd5;
  localparam logic [SEL_W-1:0] SEL_RK = 3'd6;

  typedef struct packed {
    logic             load;     // take a new point, clear step count
    logic             mul;      // register the selected product
    logic             acc;      // consume the registered product
    logic             update;   // form the next quaternion
    logic             capture;  // load the output register
    logic [SEL_W-1:0] sel;
  } qje_cmd_t;

  typedef struct packed {
    logic first;      // no step taken yet
    logic limit_hit;  // step count reached the effective limit
    logic escaped;    // accumulated norm is at least two
  } qje_status_t;

endpackage

@@ rtl/qje_datapath.sv @@
// Datapath of the quaternion Julia evaluator: component registers, one shared
// multiplier, square/cross-term registers, norm accumulator and output register.
// Depends on qje_pkg.
module qje_datapath import qje_pkg::*; #(
  parameter int MAX_ITERATIONS = 16,
  parameter int FRACTION_BITS  = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  qje_cmd_t                 cmd,
  output qje_status_t              status,
  input  logic signed [IN_W-1:0]   point_x,
  input  logic signed [IN_W-1:0]   point_y,
  input  logic signed [IN_W-1:0]   point_z,
  input  logic signed [IN_W-1:0]   const_real,
  input  logic signed [IN_W-1:0]   const_i,
  input  logic signed [IN_W-1:0]   const_j,
  input  logic signed [IN_W-1:0]   const_k,
  input  logic signed [IN_W-1:0]   slice_w,
  input  logic [LIMIT_W-1:0]       iteration_limit,
  output logic [NORM_W-1:0]        norm_squared,
  output logic [STEPS_W-1:0]       steps_used,
  output logic                     escaped
);

  localparam int W   = FRACTION_BITS + 8;       // component width
  localparam int PW  = 2 * W;                   // full product
  localparam int SQW = PW - FRACTION_BITS;      // reduced square
  localparam int CRW = SQW + 1;                 // reduced cross term
  localparam int NW  = SQW + 3;                 // next-component sum
  localparam int AW  = PW + 2;                  // norm accumulator
  localparam int NFW = AW - FRACTION_BITS;      // unsaturated norm
  localparam int SW  = $clog2(MAX_ITERATIONS + 1);
  localparam int LW  = (SW > LIMIT_W) ? SW : LIMIT_W;

  localparam logic signed [NW-1:0] COMP_HI = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [NW-1:0] COMP_LO = -COMP_HI;
  localparam logic [NFW-1:0] NORM_TWO = NFW'(2) << FRACTION_BITS;
  localparam logic [LW-1:0]  MAX_IT   = LW'(MAX_ITERATIONS);

  function automatic logic signed [W-1:0] clamp_comp(input logic signed [NW-1:0] v);
    logic signed [W-1:0] res;
    if (v > COMP_HI) begin
      res = COMP_HI[W-1:0];
    end else if (v < COMP_LO) begin
      res = COMP_LO[W-1:0];
    end else begin
      res = v[W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [NW-1:0] ext_in(input logic signed [IN_W-1:0] v);
    return {{(NW-IN_W){v[IN_W-1]}}, v};
  endfunction

  logic signed [W-1:0]   comp_r_r, comp_i_r, comp_j_r, comp_k_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [SQW-1:0] sq_r_r, sq_i_r, sq_j_r, sq_k_r;
  logic signed [CRW-1:0] cr_i_r, cr_j_r, cr_k_r;
  logic [AW-1:0]         acc_r;
  logic [SW-1:0]         steps_r;
  logic [NORM_W-1:0]     norm_out_r;
  logic [STEPS_W-1:0]    steps_out_r;
  logic                  esc_out_r;

  logic signed [W-1:0]   op_a, op_b;
  logic signed [NW-1:0]  next_r, next_i, next_j, next_k;
  logic [NFW-1:0]        norm_full;
  logic [LW-1:0]         limit_eff, steps_ext;

  always_comb begin
    op_a = comp_r_r;
    op_b = comp_r_r;
    case (cmd.sel)
      SEL_RR: begin op_a = comp_r_r; op_b = comp_r_r; end
      SEL_II: begin op_a = comp_i_r; op_b = comp_i_r; end
      SEL_JJ: begin op_a = comp_j_r; op_b = comp_j_r; end
      SEL_KK: begin op_a = comp_k_r; op_b = comp_k_r; end
      SEL_RI: begin op_a = comp_r_r; op_b = comp_i_r; end
      SEL_RJ: begin op_a = comp_r_r; op_b = comp_j_r; end
      SEL_RK: begin op_a = comp_r_r; op_b = comp_k_r; end
      default: begin op_a = comp_r_r; op_b = comp_r_r; end
    endcase
  end

  // Squares are nonnegative, so the sign-extended reduced values subtract cleanly.
  always_comb begin
    next_r = {{(NW-SQW){sq_r_r[SQW-1]}}, sq_r_r} - {{(NW-SQW){sq_i_r[SQW-1]}}, sq_i_r}
           - {{(NW-SQW){sq_j_r[SQW-1]}}, sq_j_r} - {{(NW-SQW){sq_k_r[SQW-1]}}, sq_k_r}
           + ext_in(const_real);
    next_i = {{(NW-CRW){cr_i_r[CRW-1]}}, cr_i_r} + ext_in(const_i);
    next_j = {{(NW-CRW){cr_j_r[CRW-1]}}, cr_j_r} + ext_in(const_j);
    next_k = {{(NW-CRW){cr_k_r[CRW-1]}}, cr_k_r} + ext_in(const_k);
  end

  assign norm_full = acc_r[AW-1:FRACTION_BITS];
  assign steps_ext = LW'(steps_r);

  always_comb begin
    limit_eff = LW'(iteration_limit);
    if (iteration_limit == '0) begin
      limit_eff = LW'(1);
    end else if (LW'(iteration_limit) > MAX_IT) begin
      limit_eff = MAX_IT;
    end
  end

  assign status.first     = (steps_r == '0);
  assign status.limit_hit = (steps_ext >= limit_eff);
  assign status.escaped   = (norm_full >= NORM_TWO);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.load) begin
      comp_r_r <= clamp_comp(ext_in(point_x));
      comp_i_r <= clamp_comp(ext_in(point_y));
      comp_j_r <= clamp_comp(ext_in(point_z));
      comp_k_r <= clamp_comp(ext_in(slice_w));
    end else if (cmd.update) begin
      comp_r_r <= clamp_comp(next_r);
      comp_i_r <= clamp_comp(next_i);
      comp_j_r <= clamp_comp(next_j);
      comp_k_r <= clamp_comp(next_k);
    end
    // Arithmetic right shifts of the products round toward minus infinity.
    if (cmd.acc) begin
      case (cmd.sel)
        SEL_RR:  sq_r_r <= prod_r[PW-1:FRACTION_BITS];
        SEL_II:  sq_i_r <= prod_r[PW-1:FRACTION_BITS];
        SEL_JJ:  sq_j_r <= prod_r[PW-1:FRACTION_BITS];
        SEL_KK:  sq_k_r <= prod_r[PW-1:FRACTION_BITS];
        SEL_RI:  cr_i_r <= prod_r[PW-1:FRACTION_BITS-1];
        SEL_RJ:  cr_j_r <= prod_r[PW-1:FRACTION_BITS-1];
        SEL_RK:  cr_k_r <= prod_r[PW-1:FRACTION_BITS-1];
        default: ;
      endcase
    end
    if (cmd.capture) begin
      norm_out_r  <= (norm_full > {{(NFW-NORM_W){1'b0}}, NORM_MAX}) ?
                     NORM_MAX : norm_full[NORM_W-1:0];
      steps_out_r <= steps_ext[STEPS_W-1:0];
      esc_out_r   <= status.escaped;
    end
  end

  // The exact norm is the sum of the four full squares of the current components.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      steps_r <= '0;
    end else begin
      if (cmd.load || cmd.update) begin
        acc_r <= '0;
      end else if (cmd.acc && (cmd.sel == SEL_RR || cmd.sel == SEL_II ||
                               cmd.sel == SEL_JJ || cmd.sel == SEL_KK)) begin
        acc_r <= acc_r + {{(AW-PW){1'b0}}, prod_r};
      end
      if (cmd.load) begin
        steps_r <= '0;
      end else if (cmd.update) begin
        steps_r <= steps_r + SW'(1);
      end
    end
  end

  assign norm_squared = norm_out_r;
  assign steps_used   = steps_out_r;
  assign escaped      = esc_out_r;

endmodule

@@ rtl/qje_ctrl.sv @@
// Sequencer for the quaternion Julia evaluator: steps the shared multiplier
// through squares and cross terms, decides when to stop, owns both handshakes.
// Depends on qje_pkg.
module qje_ctrl import qje_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output qje_cmd_t    cmd,
  input  qje_status_t status
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_ACC    = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [SEL_W-1:0] sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.sel       = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          sel_nxt   = SEL_RR;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (sel_r == SEL_KK) begin
          state_nxt = ST_CHECK;
        end else if (sel_r == SEL_RK) begin
          state_nxt = ST_UPDATE;
        end else begin
          sel_nxt   = sel_r + SEL_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_CHECK: begin
        // The squares of the starting point feed the first step but no exit test.
        if (!status.first && (status.limit_hit || status.escaped)) begin
          state_nxt = ST_DONE;
        end else begin
          sel_nxt   = SEL_RI;
          state_nxt = ST_MUL;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        sel_nxt    = SEL_RR;
        state_nxt  = ST_MUL;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= SEL_RR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/quaternion_julia_escape.sv @@
// Channel  | Direction | Signals                          | Payload
// input    | in        | in_tvalid/in_tready/in_tdata     | point_x, point_y, point_z
// result   | out       | out_tvalid/out_tready/out_tdata  | norm_squared, steps_used, escaped
// config   | in/out    | cfg_psel..cfg_pready (APB)       | six registers at 4*index
//
// One point is processed at a time on a single shared multiplier. Each step runs
// the four squares, a check, the three cross terms and an update, each product
// passing a multiply state and an accumulate state. rst_n is synchronous and
// active low and restores the register defaults. A finished result waits in the
// output register; the next point is accepted while it waits, and the sequencer
// stalls only if a second result is ready before the first is taken.
// Depends on qje_pkg, qje_ctrl and qje_datapath.
module quaternion_julia_escape import qje_pkg::*; #(
  parameter int MAX_ITERATIONS = 16,
  parameter int FRACTION_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,     // point_x[15:0], point_y[31:16], point_z[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // norm_squared[19:0], steps_used[24:20],
                                    // escaped[25], zero[31:26]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic signed [IN_W-1:0] const_real_r, const_i_r, const_j_r, const_k_r, slice_w_r;
  logic [LIMIT_W-1:0]     iter_limit_r;
  logic                   cfg_write;
  logic [2:0]             cfg_index;

  qje_cmd_t          cmd;
  qje_status_t       status;
  logic [NORM_W-1:0]  norm_squared;
  logic [STEPS_W-1:0] steps_used;
  logic               escaped;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_index  = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_real_r <= 16'sd2048;
      const_i_r    <= 16'sd1638;
      const_j_r    <= 16'sd4096;
      const_k_r    <= 16'sd1024;
      slice_w_r    <= -16'sd2253;
      iter_limit_r <= 5'd4;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CONST_REAL: const_real_r <= cfg_pwdata[IN_W-1:0];
        REG_CONST_I:    const_i_r    <= cfg_pwdata[IN_W-1:0];
        REG_CONST_J:    const_j_r    <= cfg_pwdata[IN_W-1:0];
        REG_CONST_K:    const_k_r    <= cfg_pwdata[IN_W-1:0];
        REG_SLICE_W:    slice_w_r    <= cfg_pwdata[IN_W-1:0];
        REG_ITER_LIMIT: iter_limit_r <= cfg_pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_CONST_REAL: cfg_prdata = {16'd0, const_real_r};
      REG_CONST_I:    cfg_prdata = {16'd0, const_i_r};
      REG_CONST_J:    cfg_prdata = {16'd0, const_j_r};
      REG_CONST_K:    cfg_prdata = {16'd0, const_k_r};
      REG_SLICE_W:    cfg_prdata = {16'd0, slice_w_r};
      REG_ITER_LIMIT: cfg_prdata = {27'd0, iter_limit_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  qje_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  qje_datapath #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .point_x         (in_tdata[15:0]),
    .point_y         (in_tdata[31:16]),
    .point_z         (in_tdata[47:32]),
    .const_real      (const_real_r),
    .const_i         (const_i_r),
    .const_j         (const_j_r),
    .const_k         (const_k_r),
    .slice_w         (slice_w_r),
    .iteration_limit (iter_limit_r),
    .norm_squared    (norm_squared),
    .steps_used      (steps_used),
    .escaped         (escaped)
  );

  assign out_tdata = {6'd0, escaped, steps_used, norm_squared};

endmodule

@@ tb/quaternion_julia_escape_test.sv @@
// Self-checking testbench for quaternion_julia_escape: streams sample points in,
// predicts each escape result in a scoreboard class and checks every output.
// Depends on qje_pkg and the quaternion_julia_escape RTL only.
`timescale 1ns / 100ps

module quaternion_julia_escape_test;
  import qje_pkg::*;

  localparam int MAX_STEPS  = 16;
  localparam int FRAC       = 12;
  localparam int LOG_LIMIT  = 10;
  localparam int TAIL_WAIT  = 16 * MAX_STEPS + 40;
  localparam logic [2:0] REG_SPARE = 3'd6;  // no register behind this index

  typedef struct packed {
    logic [NORM_W-1:0]  norm;
    logic [STEPS_W-1:0] steps;
    logic               escaped;
  } julia_outcome_t;

  class julia_scoreboard;
    longint      c_real = 2048;
    longint      c_i    = 1638;
    longint      c_j    = 4096;
    longint      c_k    = 1024;
    longint      slice  = -2253;
    int unsigned step_limit = 4;
    julia_outcome_t expected_q[$];
    int failures, n_points, n_results, n_escaped, deepest;

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_CONST_REAL: c_real = $signed(value[15:0]);
        REG_CONST_I:    c_i    = $signed(value[15:0]);
        REG_CONST_J:    c_j    = $signed(value[15:0]);
        REG_CONST_K:    c_k    = $signed(value[15:0]);
        REG_SLICE_W:    slice  = $signed(value[15:0]);
        REG_ITER_LIMIT: step_limit = value[4:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      longint lim;
      lim = (longint'(1) << (FRAC + 7)) - 1;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // Iterate q <- q*q + c until the squared norm reaches two or the limit runs out.
    function julia_outcome_t escape_time(logic signed [15:0] x, logic signed [15:0] y,
                                         logic signed [15:0] z);
      julia_outcome_t outcome;
      longint r, i, j, k, nr, ni, nj, nk, norm;
      int lim, steps;
      lim = step_limit;
      if (lim < 1) lim = 1;
      if (lim > MAX_STEPS) lim = MAX_STEPS;
      r = x;
      i = y;
      j = z;
      k = clip(slice);
      steps = 0;
      do begin
        nr = ((r * r) >>> FRAC) - ((i * i) >>> FRAC) - ((j * j) >>> FRAC)
             - ((k * k) >>> FRAC) + c_real;
        ni = ((r * i) >>> (FRAC - 1)) + c_i;
        nj = ((r * j) >>> (FRAC - 1)) + c_j;
        nk = ((r * k) >>> (FRAC - 1)) + c_k;
        r = clip(nr);
        i = clip(ni);
        j = clip(nj);
        k = clip(nk);
        steps++;
        norm = (r * r + i * i + j * j + k * k) >>> FRAC;
      end while (steps < lim && norm < (longint'(2) << FRAC));
      outcome.norm    = (norm > longint'(NORM_MAX)) ? NORM_MAX : norm[NORM_W-1:0];
      outcome.steps   = steps[STEPS_W-1:0];
      outcome.escaped = (norm >= (longint'(2) << FRAC));
      return outcome;
    endfunction

    function void note_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      expected_q.push_back(escape_time(x, y, z));
      n_points++;
    endfunction

    function void check_result(logic [31:0] word);
      julia_outcome_t got, want;
      got.norm    = word[19:0];
      got.steps   = word[24:20];
      got.escaped = word[25];
      n_results++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= LOG_LIMIT)
          $display("ERROR: result with nothing pending: norm=%0d steps=%0d escaped=%0b",
                   got.norm, got.steps, got.escaped);
        return;
      end
      want = expected_q.pop_front();
      if (want.escaped) n_escaped++;
      if (want.steps > deepest) deepest = want.steps;
      if (got.norm !== want.norm || got.steps !== want.steps
          || got.escaped !== want.escaped) begin
        failures++;
        if (failures <= LOG_LIMIT)
          $display("ERROR: result %0d: norm %0d/%0d steps %0d/%0d escaped %0b/%0b (exp/got)",
                   n_results, want.norm, got.norm, want.steps, got.steps,
                   want.escaped, got.escaped);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;  // point_x[15:0], point_y[31:16], point_z[47:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;      // norm_squared[19:0], steps_used[24:20], escaped[25]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  julia_scoreboard sb = new();
  bit sender_eager, receiver_eager;
  int hold_off_cycles;
  int settings_used;

  quaternion_julia_escape #(
    .MAX_ITERATIONS(MAX_STEPS),
    .FRACTION_BITS (FRAC)
  ) dut (.*);

  always #2 clk = ~clk;

  function automatic int draw_wait(bit eager);
    return eager ? 0 : int'($urandom_range(0, 17));
  endfunction

  // Mostly points with every coordinate within two of zero, where orbits run for several steps.
  function automatic logic [15:0] draw_coord();
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1, 2: v = int'($urandom_range(0, 4096)) - 2048;
      default: v = int'($urandom_range(0, 16384)) - 8192;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] draw_constant();
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? 32767 : -32768;
      1: v = $urandom;
      default: v = int'($urandom_range(0, 8192)) - 4096;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [4:0] draw_limit();
    return ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                       : 5'($urandom_range(1, 16));
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_register(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_julia(input logic [15:0] cr, ci, cj, ck, w, input logic [4:0] lim);
    write_reg(REG_CONST_REAL, {{16{cr[15]}}, cr});
    write_reg(REG_CONST_I,    {{16{ci[15]}}, ci});
    write_reg(REG_CONST_J,    {{16{cj[15]}}, cj});
    write_reg(REG_CONST_K,    {{16{ck[15]}}, ck});
    write_reg(REG_SLICE_W,    {{16{w[15]}}, w});
    write_reg(REG_ITER_LIMIT, {27'b0, lim});
    settings_used++;
  endtask

  // in_tvalid stays high across back-to-back points and drops only for a gap or a stop.
  task automatic send_point(input logic [15:0] x, y, z);
    int gap;
    gap = draw_wait(sender_eager);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_point(x, y, z);
  endtask

  task automatic stop_points();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        stall_left = draw_wait(receiver_eager);
      end
      // A long hold-off lets the block fill up and back-pressure the input.
      if (hold_off_cycles > 0) begin
        stall_left = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults after reset, with the coordinate extremes.
    settings_used = 1;
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7FFF, 16'h8000, 16'h0000);
    send_point(16'h1000, 16'h0000, 16'h0000);
    send_point(16'hF000, 16'h1000, 16'hF000);
    stop_points();
    wait_drained();

    // A zero limit still takes one step.
    set_julia(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h0800, 16'h0800, 16'h0000);
    stop_points();
    wait_drained();

    // A limit above the maximum is cut back; these orbits never escape.
    set_julia(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd31);
    send_point(16'h1000, 16'h0000, 16'h0000);
    send_point(16'h0800, 16'h0000, 16'h0000);
    send_point(16'h0000, 16'h0000, 16'h0000);
    stop_points();
    wait_drained();

    // Extreme constants drive the components and the norm into saturation.
    set_julia(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 5'd16);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(16'h0000, 16'h0000, 16'h0000);
    stop_points();
    wait_drained();
    set_julia(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 5'd1);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7FFF, 16'h0000, 16'h8000);
    stop_points();
    wait_drained();

    // Small constant: points near the escape boundary.
    set_julia(16'h0400, 16'h0200, 16'hFE00, 16'h0100, 16'h0000, 5'd16);
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h1666, 16'h0000, 16'h0000);
    send_point(16'h0C00, 16'hF800, 16'h0400);
    stop_points();
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      sender_eager   = ($urandom_range(0, 3) == 0);
      receiver_eager = ($urandom_range(0, 3) == 0);
      set_julia(draw_constant(), draw_constant(), draw_constant(), draw_constant(),
                draw_constant(), draw_limit());
      if (phase == 3) write_reg(REG_SPARE, $urandom);
      for (int n = 0; n < 80; n++) begin
        if (phase == 2 && n == 10) hold_off_cycles = 1500;
        if (phase == 5 && n == 40) begin
          stop_points();
          wait_drained();
        end
        send_point(draw_coord(), draw_coord(), draw_coord());
      end
      stop_points();
      wait_drained();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    $display("Sent %0d points under %0d register settings, %0d results checked.",
             sb.n_points, settings_used, sb.n_results);
    $display("%0d points escaped; the longest orbit ran %0d steps; %0d mismatches.",
             sb.n_escaped, sb.deepest, sb.failures);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("quaternion_julia_escape test passed");
    end else begin
      $display("quaternion_julia_escape test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("Timed out with %0d results still pending.", sb.expected_q.size());
    $display("quaternion_julia_escape test failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/qje_pkg.sv
rtl/qje_datapath.sv
rtl/qje_ctrl.sv
rtl/quaternion_julia_escape.sv
tb/quaternion_julia_escape_test.sv
